// ===== src/assert_macros.svh =====
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define HSFC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hsfc: implication check failed");

// Next-cycle implication, masked while reset is high.
`define HSFC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hsfc: next-cycle check failed");

// Next-cycle implication that also holds across reset.
`define HSFC_ASSERT_NXT_ALL(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("hsfc: next-cycle check failed");

`endif

// ===== src/hsfc_pkg.sv =====
// Types, constants and round functions for the flow cookie hash pipeline.
package hsfc_pkg;

  localparam logic [31:0] HS_C0          = 32'h7073_6575;
  localparam logic [31:0] HS_C1          = 32'h6e64_6f6d;
  localparam logic [31:0] HS_C2          = 32'h6e65_7261;
  localparam logic [31:0] HS_C3          = 32'h7974_6573;
  localparam logic [31:0] KEY_LOW_RESET  = 32'h3332_3130;
  localparam logic [31:0] KEY_HIGH_RESET = 32'h4241_3938;
  localparam logic [31:0] FINAL_XOR      = 32'h0000_00ff;

  localparam int NUM_ROUNDS = 10;

  // Rounds after which message words are folded in.
  localparam int RND_ABSORB_SRC  = 1;
  localparam int RND_ABSORB_DST  = 3;
  localparam int RND_ABSORB_PORT = 5;

  // Configuration register indexes.
  localparam logic CFG_KEY_LOW  = 1'b0;
  localparam logic CFG_KEY_HIGH = 1'b1;

  typedef struct packed {
    logic [31:0] v3;
    logic [31:0] v2;
    logic [31:0] v1;
    logic [31:0] v0;
  } hsfc_state_t;

  typedef struct packed {
    hsfc_state_t st;
    logic [31:0] msg_port;
    logic [31:0] msg_dst;
    logic [31:0] msg_src;
  } hsfc_item_t;

  typedef struct packed {
    logic [31:0] x3;
    logic [31:0] x2;
    logic [31:0] x0;
  } hsfc_inject_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction

  // One ARX round.
  function automatic hsfc_state_t hsfc_round(input hsfc_state_t s);
    logic [31:0] v0, v1, v2, v3;
    v0 = s.v0 + s.v1;
    v2 = s.v2 + s.v3;
    v1 = rotl(s.v1, 5) ^ v0;
    v3 = rotl(s.v3, 8) ^ v2;
    v0 = rotl(v0, 16);
    v2 = v2 + v1;
    v0 = v0 + v3;
    v1 = rotl(v1, 13) ^ v2;
    v3 = rotl(v3, 7) ^ v0;
    v2 = rotl(v2, 16);
    hsfc_round = '{v3: v3, v2: v2, v1: v1, v0: v0};
  endfunction

  // Words XORed into the state after a given round.
  function automatic hsfc_inject_t hsfc_inject(input int rnd, input hsfc_item_t it);
    hsfc_inject_t x;
    x = '0;
    if (rnd == RND_ABSORB_SRC) begin
      x.x0 = it.msg_src;
      x.x3 = it.msg_dst;
    end else if (rnd == RND_ABSORB_DST) begin
      x.x0 = it.msg_dst;
      x.x3 = it.msg_port;
    end else if (rnd == RND_ABSORB_PORT) begin
      x.x0 = it.msg_port;
      x.x2 = FINAL_XOR;
    end
    hsfc_inject = x;
  endfunction

endpackage

// ===== src/hsfc_stage.sv =====
// One pipeline stage: a single ARX round followed by message injection.
module hsfc_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  hsfc_pkg::hsfc_item_t  in_item,
  input  hsfc_pkg::hsfc_inject_t inject,
  output logic                  out_valid,
  input  logic                  out_ready,
  output hsfc_pkg::hsfc_item_t  out_item
);

  hsfc_pkg::hsfc_state_t rnd;
  hsfc_pkg::hsfc_item_t  item_next;
  logic                  valid;
  hsfc_pkg::hsfc_item_t  item;

  always_comb begin
    rnd          = hsfc_pkg::hsfc_round(in_item.st);
    item_next    = in_item;
    item_next.st = '{v3: rnd.v3 ^ inject.x3, v2: rnd.v2 ^ inject.x2,
                     v1: rnd.v1, v0: rnd.v0 ^ inject.x0};
  end

  // Stage loads when empty or when its content moves on.
  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= item_next;
    end
  end

  assign out_valid = valid;
  assign out_item  = item;

endmodule

// ===== src/hsfc_fold.sv =====
// Output stage: XOR-folds the final state into the cookie register.
module hsfc_fold (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  hsfc_pkg::hsfc_state_t in_state,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [31:0]           out_hash
);

  logic        valid;
  logic [31:0] hash;

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hash <= in_state.v0 ^ in_state.v1 ^ in_state.v2 ^ in_state.v3;
    end
  end

  assign out_valid = valid;
  assign out_hash  = hash;

endmodule

// ===== src/halfsiphash_flow_cookie.sv =====
// Top level of the keyed flow cookie hash: config registers, init and round pipeline.
//
// Usage:
//  - s_axis carries one flow tuple per transaction; m_axis returns one 32-bit
//    cookie per transaction, in the same order.
//  - Keys are loaded through cfg_wr/cfg_index/cfg_data (index 0 key_low,
//    index 1 key_high) and must only change while the pipeline is empty.
//  - Ten register stages each run one ARX round, with the message words and
//    the finalisation constant folded in after the second, fourth and sixth
//    rounds; an eleventh register holds the XOR-folded cookie.
//  - A transaction passes through the ten round registers and then the fold
//    register, whose output drives m_axis_tvalid and m_axis_tdata.
//  - Throughput: one transaction per cycle while m_axis is not stalled; each
//    stage is one round, i.e. two dependent 32-bit adds deep.
//  - Every stage has its own valid bit and ready, so bubbles close up and new
//    input is taken while a finished cookie waits, until all 11 stages fill.
//  - When m_axis stalls, the pipeline holds; nothing is dropped or repeated.
//  - Reset (rst, synchronous) empties the pipeline and restores the key
//    defaults.
module halfsiphash_flow_cookie (
  input  logic        clk,
  input  logic        rst,
  // Flow tuple, from bit 0: source_address[31:0], dest_address[31:0],
  // source_port_num[15:0], dest_port_num[15:0]
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,
  // Cookie, from bit 0: cookie_hash[31:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,
  // Key write port
  input  logic        cfg_wr,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0] key_low;
  logic [31:0] key_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= hsfc_pkg::KEY_LOW_RESET;
      key_high <= hsfc_pkg::KEY_HIGH_RESET;
    end else if (cfg_wr) begin
      case (cfg_index)
        hsfc_pkg::CFG_KEY_LOW:  key_low  <= cfg_data;
        hsfc_pkg::CFG_KEY_HIGH: key_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // Field unpacking and initial state (first message word already in v3).
  logic [31:0] source_address;
  logic [31:0] dest_address;
  logic [15:0] source_port_num;
  logic [15:0] dest_port_num;
  hsfc_pkg::hsfc_item_t init_item;

  assign source_address  = s_axis_tdata[31:0];
  assign dest_address    = s_axis_tdata[63:32];
  assign source_port_num = s_axis_tdata[79:64];
  assign dest_port_num   = s_axis_tdata[95:80];

  always_comb begin
    init_item.msg_src  = source_address;
    init_item.msg_dst  = dest_address;
    init_item.msg_port = {source_port_num, dest_port_num};
    init_item.st.v0    = hsfc_pkg::HS_C0 ^ key_low;
    init_item.st.v1    = hsfc_pkg::HS_C1 ^ key_high;
    init_item.st.v2    = hsfc_pkg::HS_C2 ^ key_low;
    init_item.st.v3    = hsfc_pkg::HS_C3 ^ key_high ^ source_address;
  end

  // Round pipeline; link k feeds stage k.
  logic                  lnk_valid [hsfc_pkg::NUM_ROUNDS+1];
  logic                  lnk_ready [hsfc_pkg::NUM_ROUNDS+1];
  hsfc_pkg::hsfc_item_t  lnk_item  [hsfc_pkg::NUM_ROUNDS+1];

  assign lnk_valid[0]   = s_axis_tvalid;
  assign lnk_item[0]    = init_item;
  assign s_axis_tready  = lnk_ready[0];

  for (genvar k = 0; k < hsfc_pkg::NUM_ROUNDS; k++) begin : g_round
    hsfc_pkg::hsfc_inject_t inj;
    assign inj = hsfc_pkg::hsfc_inject(k, lnk_item[k]);

    hsfc_stage u_stage (
      .clk      (clk),
      .rst      (rst),
      .in_valid (lnk_valid[k]),
      .in_ready (lnk_ready[k]),
      .in_item  (lnk_item[k]),
      .inject   (inj),
      .out_valid(lnk_valid[k+1]),
      .out_ready(lnk_ready[k+1]),
      .out_item (lnk_item[k+1])
    );
  end

  // Final XOR fold doubles as the output register.
  hsfc_fold u_fold (
    .clk      (clk),
    .rst      (rst),
    .in_valid (lnk_valid[hsfc_pkg::NUM_ROUNDS]),
    .in_ready (lnk_ready[hsfc_pkg::NUM_ROUNDS]),
    .in_state (lnk_item[hsfc_pkg::NUM_ROUNDS].st),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_hash (m_axis_tdata)
  );

endmodule

// ===== src/hsfc_checker.sv =====
// Port-level checks for the flow cookie block, bound to the top level.
`include "assert_macros.svh"

module hsfc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  // Reset empties the pipeline, so no cookie is offered right after it.
  `HSFC_ASSERT_NXT_ALL(a_reset_empty, clk, rst, !m_axis_tvalid)

  // An empty output register means the whole chain can take input.
  `HSFC_ASSERT_IMP(a_ready_when_out_empty, clk, rst, !m_axis_tvalid, s_axis_tready)

  // Input backpressure only ever comes from a waiting cookie.
  `HSFC_ASSERT_IMP(a_stall_from_output, clk, rst, !s_axis_tready, m_axis_tvalid && !m_axis_tready)

  // A stalled cookie holds.
  `HSFC_ASSERT_NXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind halfsiphash_flow_cookie hsfc_checker u_hsfc_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
